// ===== rtl/core/frst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frst_pkg
// Shared widths, constants and types of the frame rate statistics tracker.
// ----------------------------------------------------------------------------
package frst_pkg;

  localparam int RATE_FRAC_BITS = 8;
  localparam int AVG_EXTRA_BITS = 16;

  localparam int RATE_W   = 18;
  localparam int COMP_W   = 20;
  localparam int NUM_COMP = 6;
  localparam int TIME_W   = 32;
  localparam int KEEP_W   = 16;
  localparam int WK_W     = KEEP_W + 1;
  localparam int Q16_SHIFT = 16;

  localparam int SUM_W = $clog2(NUM_COMP * ((1 << COMP_W) - 1) + 1);
  localparam int CNT_W = $clog2(NUM_COMP);

  localparam longint unsigned RATE_NUM_L = 64'd1000000 << RATE_FRAC_BITS;
  localparam int NUM_W    = $clog2(RATE_NUM_L + 1);
  localparam int DCNT_W   = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(RATE_NUM_L);

  localparam longint unsigned CAP_RAW_L   = 64'd999 << RATE_FRAC_BITS;
  localparam longint unsigned FIELD_MAX_L = (64'd1 << RATE_W) - 1;
  localparam logic [RATE_W-1:0] RATE_CAP =
    RATE_W'((CAP_RAW_L < FIELD_MAX_L) ? CAP_RAW_L : FIELD_MAX_L);

  localparam logic [SUM_W-1:0] SHORT_US = SUM_W'(100);

  localparam int AVG_W  = RATE_W + AVG_EXTRA_BITS;
  localparam int PROD_W = AVG_W + WK_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic [WK_W-1:0]  ONE_Q16    = WK_W'(65536);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEDICATED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP      = 2'd2;

  localparam logic [15:0]       SETTLE_RESET = 16'd10000;
  localparam logic [KEEP_W-1:0] KEEP_RESET   = 16'd64881;

  typedef struct packed {
    logic mul_en;
    logic acc_init;
    logic acc_add;
  } mac_ctl_t;

endpackage

// ===== rtl/core/frst_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frst_in_if
// Frame beat channel: activity, time stamp and six timing components.
// ----------------------------------------------------------------------------
interface frst_in_if;
  logic                         valid;
  logic                         ready;
  logic                         active;
  logic [frst_pkg::TIME_W-1:0]  now_ms;
  logic [frst_pkg::COMP_W-1:0]  input_us;
  logic [frst_pkg::COMP_W-1:0]  client_us;
  logic [frst_pkg::COMP_W-1:0]  render_us;
  logic [frst_pkg::COMP_W-1:0]  sound_us;
  logic [frst_pkg::COMP_W-1:0]  module_us;
  logic [frst_pkg::COMP_W-1:0]  exec_us;

  modport source (
    output valid, active, now_ms, input_us, client_us, render_us,
           sound_us, module_us, exec_us,
    input  ready
  );

  modport sink (
    input  valid, active, now_ms, input_us, client_us, render_us,
           sound_us, module_us, exec_us,
    output ready
  );
endinterface

// ===== rtl/core/frst_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frst_out_if
// Statistics beat channel: counted flag, validity and five rate fields.
// ----------------------------------------------------------------------------
interface frst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        counted;
  logic                        stats_valid;
  logic [frst_pkg::RATE_W-1:0] min_rate;
  logic [frst_pkg::RATE_W-1:0] max_rate;
  logic [frst_pkg::RATE_W-1:0] avg_rate;
  logic [frst_pkg::RATE_W-1:0] min_avg_rate;
  logic [frst_pkg::RATE_W-1:0] max_avg_rate;

  modport source (
    output valid, counted, stats_valid, min_rate, max_rate, avg_rate,
           min_avg_rate, max_avg_rate,
    input  ready
  );

  modport sink (
    input  valid, counted, stats_valid, min_rate, max_rate, avg_rate,
           min_avg_rate, max_avg_rate,
    output ready
  );
endinterface

// ===== rtl/core/frst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frst_div
// Bit-serial restoring divider: fixed rate numerator over the frame time sum.
// ----------------------------------------------------------------------------
module frst_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [frst_pkg::SUM_W-1:0]    divisor,
  output logic                          done,
  output logic [frst_pkg::NUM_W-1:0]    quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [frst_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [frst_pkg::SUM_W-1:0]    rem_r, rem_nxt;
  logic [frst_pkg::NUM_W-1:0]    quot_r, quot_nxt;
  logic [frst_pkg::SUM_W:0]      trial;
  logic                          ge;

  assign trial = {rem_r, frst_pkg::RATE_NUM[cnt_r]};
  assign ge    = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = frst_pkg::DCNT_W'(frst_pkg::NUM_W - 1);
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? frst_pkg::SUM_W'(trial - {1'b0, divisor})
                    : frst_pkg::SUM_W'(trial);
      quot_nxt = {quot_r[frst_pkg::NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/core/frst_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frst_mac
// Shared multiplier with product register and rounding accumulator.
// ----------------------------------------------------------------------------
module frst_mac (
  input  logic                        clk,
  input  frst_pkg::mac_ctl_t          ctl,
  input  logic [frst_pkg::AVG_W-1:0]  a,
  input  logic [frst_pkg::WK_W-1:0]   b,
  output logic [frst_pkg::ACC_W-1:0]  acc
);

  logic [frst_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [frst_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (ctl.mul_en) begin
      prod_nxt = frst_pkg::PROD_W'(a) * frst_pkg::PROD_W'(b);
    end
    if (ctl.acc_init) begin
      acc_nxt = frst_pkg::ACC_W'(prod_r) + frst_pkg::ROUND_HALF;
    end else if (ctl.acc_add) begin
      acc_nxt = acc_r + (frst_pkg::ACC_W'(prod_r) << frst_pkg::AVG_EXTRA_BITS);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/frame_rate_statistics_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_statistics_tracker_core
// Frame rate tracker: instantaneous min/max, exponential average and its
// min/max, with a settle window after the client becomes active.
// ----------------------------------------------------------------------------
// One frame beat is taken at a time and yields one statistics beat. A frame
// that is skipped (inactive, dedicated mode, first active frame or inside the
// settle window) goes from accept to the output register through S_EMIT. A
// counted frame adds the timing components one per cycle, forms the rate in
// the bit-serial divider one quotient bit per cycle and updates the average
// on the shared multiplier and accumulator; a sum below 100 us skips the
// divider. The result sits in an output register, so the next frame is taken
// as soon as the sequencer is back in idle; it waits only if an earlier
// result has not been taken yet.
module frame_rate_statistics_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  frst_in_if.sink                           in_ch,
  frst_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [frst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frst_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_RATE, S_DIV, S_MUL_OLD, S_MUL_NEW, S_ACC, S_UPD, S_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [frst_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [frst_pkg::COMP_W-1:0]   comp_r   [frst_pkg::NUM_COMP];
  logic [frst_pkg::COMP_W-1:0]   comp_nxt [frst_pkg::NUM_COMP];
  logic [frst_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [frst_pkg::RATE_W-1:0]   rate_r, rate_nxt;
  logic [frst_pkg::AVG_W-1:0]    avg_r, avg_nxt;
  logic [frst_pkg::RATE_W-1:0]   min_rate_r, min_rate_nxt;
  logic [frst_pkg::RATE_W-1:0]   max_rate_r, max_rate_nxt;
  logic [frst_pkg::RATE_W-1:0]   min_avg_r, min_avg_nxt;
  logic [frst_pkg::RATE_W-1:0]   max_avg_r, max_avg_nxt;
  logic                          have_stats_r, have_stats_nxt;
  logic                          settle_started_r, settle_started_nxt;
  logic [frst_pkg::TIME_W-1:0]   deadline_r, deadline_nxt;
  logic                          counted_r, counted_nxt;

  logic                          ded_r, ded_nxt;
  logic [15:0]                   settle_ms_r, settle_ms_nxt;
  logic [frst_pkg::KEEP_W-1:0]   keep_r, keep_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          o_counted_r, o_counted_nxt;
  logic                          o_stats_r, o_stats_nxt;
  logic [frst_pkg::RATE_W-1:0]   o_min_r, o_min_nxt;
  logic [frst_pkg::RATE_W-1:0]   o_max_r, o_max_nxt;
  logic [frst_pkg::RATE_W-1:0]   o_avg_r, o_avg_nxt;
  logic [frst_pkg::RATE_W-1:0]   o_min_avg_r, o_min_avg_nxt;
  logic [frst_pkg::RATE_W-1:0]   o_max_avg_r, o_max_avg_nxt;

  logic                          in_beat;
  logic [frst_pkg::TIME_W-1:0]   left;
  logic                          window_done;
  logic                          div_start;
  logic                          div_done;
  logic [frst_pkg::NUM_W-1:0]    div_quot;
  frst_pkg::mac_ctl_t            mac_ctl;
  logic [frst_pkg::AVG_W-1:0]    mac_a;
  logic [frst_pkg::WK_W-1:0]     mac_b;
  logic [frst_pkg::ACC_W-1:0]    mac_acc;
  logic [frst_pkg::AVG_W-1:0]    target;
  logic [frst_pkg::AVG_W-1:0]    new_avg;
  logic [frst_pkg::RATE_W-1:0]   new_avg_q;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign left        = deadline_r - in_ch.now_ms;
  assign window_done = (left == '0) || left[frst_pkg::TIME_W-1];

  assign target    = frst_pkg::AVG_W'(rate_r) << frst_pkg::AVG_EXTRA_BITS;
  assign new_avg   = mac_acc[frst_pkg::Q16_SHIFT +: frst_pkg::AVG_W];
  assign new_avg_q = new_avg[frst_pkg::AVG_EXTRA_BITS +: frst_pkg::RATE_W];

  assign div_start = (state_r == S_RATE) && (sum_r >= frst_pkg::SHORT_US);

  always_comb begin
    mac_ctl.mul_en   = (state_r == S_MUL_OLD) || (state_r == S_MUL_NEW);
    mac_ctl.acc_init = (state_r == S_MUL_NEW);
    mac_ctl.acc_add  = (state_r == S_ACC);
    if (state_r == S_MUL_OLD) begin
      mac_a = have_stats_r ? avg_r : target;
      mac_b = frst_pkg::WK_W'(keep_r);
    end else begin
      mac_a = frst_pkg::AVG_W'(rate_r);
      mac_b = frst_pkg::ONE_Q16 - frst_pkg::WK_W'(keep_r);
    end
  end

  frst_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (sum_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  frst_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  // configuration writes
  always_comb begin
    ded_nxt       = ded_r;
    settle_ms_nxt = settle_ms_r;
    keep_nxt      = keep_r;
    if (cfg_we) begin
      unique case (cfg_index)
        frst_pkg::CFG_DEDICATED: ded_nxt       = cfg_data[0];
        frst_pkg::CFG_SETTLE:    settle_ms_nxt = cfg_data;
        frst_pkg::CFG_KEEP:      keep_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    comp_nxt           = comp_r;
    sum_nxt            = sum_r;
    rate_nxt           = rate_r;
    avg_nxt            = avg_r;
    min_rate_nxt       = min_rate_r;
    max_rate_nxt       = max_rate_r;
    min_avg_nxt        = min_avg_r;
    max_avg_nxt        = max_avg_r;
    have_stats_nxt     = have_stats_r;
    settle_started_nxt = settle_started_r;
    deadline_nxt       = deadline_r;
    counted_nxt        = counted_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    o_counted_nxt      = o_counted_r;
    o_stats_nxt        = o_stats_r;
    o_min_nxt          = o_min_r;
    o_max_nxt          = o_max_r;
    o_avg_nxt          = o_avg_r;
    o_min_avg_nxt      = o_min_avg_r;
    o_max_avg_nxt      = o_max_avg_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          counted_nxt = 1'b0;
          state_nxt   = S_EMIT;
          if (!ded_r) begin
            if (!in_ch.active) begin
              settle_started_nxt = 1'b0;
            end else if (!settle_started_r) begin
              settle_started_nxt = 1'b1;
              deadline_nxt       = in_ch.now_ms + frst_pkg::TIME_W'(settle_ms_r);
            end else if (window_done) begin
              counted_nxt = 1'b1;
              state_nxt   = S_SUM;
              cnt_nxt     = '0;
              sum_nxt     = '0;
              comp_nxt[0] = in_ch.input_us;
              comp_nxt[1] = in_ch.client_us;
              comp_nxt[2] = in_ch.render_us;
              comp_nxt[3] = in_ch.sound_us;
              comp_nxt[4] = in_ch.module_us;
              comp_nxt[5] = in_ch.exec_us;
            end
          end
        end
      end
      S_SUM: begin
        sum_nxt = sum_r + frst_pkg::SUM_W'(comp_r[0]);
        for (int i = 0; i < frst_pkg::NUM_COMP - 1; i++) begin
          comp_nxt[i] = comp_r[i+1];
        end
        comp_nxt[frst_pkg::NUM_COMP-1] = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == frst_pkg::CNT_W'(frst_pkg::NUM_COMP - 1)) begin
          state_nxt = S_RATE;
        end
      end
      S_RATE: begin
        if (sum_r < frst_pkg::SHORT_US) begin
          rate_nxt  = frst_pkg::RATE_CAP;
          state_nxt = S_MUL_OLD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          rate_nxt  = (div_quot > frst_pkg::NUM_W'(frst_pkg::RATE_CAP))
                      ? frst_pkg::RATE_CAP : div_quot[frst_pkg::RATE_W-1:0];
          state_nxt = S_MUL_OLD;
        end
      end
      S_MUL_OLD: state_nxt = S_MUL_NEW;
      S_MUL_NEW: state_nxt = S_ACC;
      S_ACC:     state_nxt = S_UPD;
      S_UPD: begin
        avg_nxt = new_avg;
        if (!have_stats_r) begin
          min_rate_nxt = rate_r;
          max_rate_nxt = rate_r;
          min_avg_nxt  = new_avg_q;
          max_avg_nxt  = new_avg_q;
        end else begin
          if (rate_r < min_rate_r)    min_rate_nxt = rate_r;
          if (rate_r > max_rate_r)    max_rate_nxt = rate_r;
          if (new_avg_q < min_avg_r)  min_avg_nxt  = new_avg_q;
          if (new_avg_q > max_avg_r)  max_avg_nxt  = new_avg_q;
        end
        have_stats_nxt = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_counted_nxt = counted_r;
          o_stats_nxt   = have_stats_r;
          o_min_nxt     = min_rate_r;
          o_max_nxt     = max_rate_r;
          o_avg_nxt     = avg_r[frst_pkg::AVG_EXTRA_BITS +: frst_pkg::RATE_W];
          o_min_avg_nxt = min_avg_r;
          o_max_avg_nxt = max_avg_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      have_stats_r     <= 1'b0;
      settle_started_r <= 1'b0;
      deadline_r       <= '0;
      avg_r            <= '0;
      min_rate_r       <= '0;
      max_rate_r       <= '0;
      min_avg_r        <= '0;
      max_avg_r        <= '0;
      out_valid_r      <= 1'b0;
      ded_r            <= 1'b0;
      settle_ms_r      <= frst_pkg::SETTLE_RESET;
      keep_r           <= frst_pkg::KEEP_RESET;
    end else begin
      state_r          <= state_nxt;
      have_stats_r     <= have_stats_nxt;
      settle_started_r <= settle_started_nxt;
      deadline_r       <= deadline_nxt;
      avg_r            <= avg_nxt;
      min_rate_r       <= min_rate_nxt;
      max_rate_r       <= max_rate_nxt;
      min_avg_r        <= min_avg_nxt;
      max_avg_r        <= max_avg_nxt;
      out_valid_r      <= out_valid_nxt;
      ded_r            <= ded_nxt;
      settle_ms_r      <= settle_ms_nxt;
      keep_r           <= keep_nxt;
    end
    cnt_r       <= cnt_nxt;
    comp_r      <= comp_nxt;
    sum_r       <= sum_nxt;
    rate_r      <= rate_nxt;
    counted_r   <= counted_nxt;
    o_counted_r <= o_counted_nxt;
    o_stats_r   <= o_stats_nxt;
    o_min_r     <= o_min_nxt;
    o_max_r     <= o_max_nxt;
    o_avg_r     <= o_avg_nxt;
    o_min_avg_r <= o_min_avg_nxt;
    o_max_avg_r <= o_max_avg_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.counted      = o_counted_r;
  assign out_ch.stats_valid  = o_stats_r;
  assign out_ch.min_rate     = o_min_r;
  assign out_ch.max_rate     = o_max_r;
  assign out_ch.avg_rate     = o_avg_r;
  assign out_ch.min_avg_rate = o_min_avg_r;
  assign out_ch.max_avg_rate = o_max_avg_r;

`ifndef NO_ASSERTIONS
  a_counted_has_stats: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.counted) |-> out_ch.stats_valid)
    else $error("counted beat without valid statistics");

  a_ordered_stats: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stats_valid) |->
      (out_ch.min_rate <= out_ch.max_rate) &&
      (out_ch.min_avg_rate <= out_ch.avg_rate) &&
      (out_ch.avg_rate <= out_ch.max_avg_rate))
    else $error("statistics out of order");

  a_rate_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (rate_r <= frst_pkg::RATE_CAP))
    else $error("rate above cap");

  a_dedicated_keeps_window: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && ded_r) |=> ($stable(settle_started_r) && $stable(deadline_r)))
    else $error("settle window changed in dedicated mode");
`endif

endmodule

// ===== sim/frame_rate_statistics_tracker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_statistics_tracker_core_test
// Self-checking bench for the frame rate statistics tracker. A directed run
// covers the settle window, the short and saturated frame rates and time
// stamp wrap. It is followed by phases of random frames under changing
// register settings, dedicated mode among them. A scoreboard class predicts
// every statistics beat and compares each field. Both channels idle at
// random, and the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module frame_rate_statistics_tracker_core_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 10;
  localparam logic [frst_pkg::RATE_W-1:0] FPS_CAP =
    frst_pkg::RATE_W'(999 << frst_pkg::RATE_FRAC_BITS);

  typedef struct packed {
    logic                                                   active;
    logic [frst_pkg::TIME_W-1:0]                            now_ms;
    logic [frst_pkg::NUM_COMP-1:0][frst_pkg::COMP_W-1:0]    comp;
  } frame_t;

  typedef struct packed {
    logic                        counted;
    logic                        stats_valid;
    logic [frst_pkg::RATE_W-1:0] min_rate;
    logic [frst_pkg::RATE_W-1:0] max_rate;
    logic [frst_pkg::RATE_W-1:0] avg_rate;
    logic [frst_pkg::RATE_W-1:0] min_avg_rate;
    logic [frst_pkg::RATE_W-1:0] max_avg_rate;
  } stats_t;

  class stats_scoreboard;
    logic                          dedicated;
    logic [15:0]                   settle_ms;
    logic [frst_pkg::KEEP_W-1:0]   keep;
    logic                          settle_open;
    logic [frst_pkg::TIME_W-1:0]   deadline;
    logic                          seen_stats;
    logic [frst_pkg::RATE_W-1:0]   least_fps;
    logic [frst_pkg::RATE_W-1:0]   most_fps;
    logic [frst_pkg::RATE_W-1:0]   least_avg;
    logic [frst_pkg::RATE_W-1:0]   most_avg;
    logic [63:0]                   avg_acc;
    stats_t                        predicted[$];
    int                            mismatch_count;

    function new();
      dedicated      = 1'b0;
      settle_ms      = frst_pkg::SETTLE_RESET;
      keep           = frst_pkg::KEEP_RESET;
      settle_open    = 1'b0;
      deadline       = '0;
      seen_stats     = 1'b0;
      least_fps      = '0;
      most_fps       = '0;
      least_avg      = '0;
      most_avg       = '0;
      avg_acc        = '0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [frst_pkg::CFG_IDX_W-1:0] idx,
                          logic [frst_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        frst_pkg::CFG_DEDICATED: dedicated = data[0];
        frst_pkg::CFG_SETTLE:    settle_ms = data;
        frst_pkg::CFG_KEEP:      keep = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function void note_frame(frame_t f);
      stats_t                      e;
      logic [frst_pkg::TIME_W-1:0] left;
      logic [63:0]                 sum;
      logic [63:0]                 quo;
      logic [63:0]                 target;
      logic [frst_pkg::RATE_W-1:0] fps;
      logic [frst_pkg::RATE_W-1:0] avg;
      e = '0;
      if (!dedicated) begin
        if (!f.active) begin
          settle_open = 1'b0;
        end else if (!settle_open) begin
          settle_open = 1'b1;
          deadline    = f.now_ms + frst_pkg::TIME_W'(settle_ms);
        end else begin
          left = deadline - f.now_ms;
          if (left == '0 || left[frst_pkg::TIME_W-1]) begin
            sum = '0;
            for (int i = 0; i < frst_pkg::NUM_COMP; i++) sum += f.comp[i];
            if (sum < 64'd100) begin
              fps = FPS_CAP;
            end else begin
              quo = (64'd1000000 << frst_pkg::RATE_FRAC_BITS) / sum;
              fps = (quo > FPS_CAP) ? FPS_CAP : frst_pkg::RATE_W'(quo);
            end
            target = 64'(fps) << frst_pkg::AVG_EXTRA_BITS;
            if (!seen_stats) begin
              least_fps = fps;
              most_fps  = fps;
              avg_acc   = target;
            end else begin
              if (fps < least_fps) least_fps = fps;
              if (fps > most_fps) most_fps = fps;
            end
            avg_acc = (avg_acc * 64'(keep) + (64'd65536 - 64'(keep)) * target
                       + 64'd32768) >> 16;
            avg = frst_pkg::RATE_W'(avg_acc >> frst_pkg::AVG_EXTRA_BITS);
            if (!seen_stats) begin
              least_avg = avg;
              most_avg  = avg;
            end else begin
              if (avg < least_avg) least_avg = avg;
              if (avg > most_avg) most_avg = avg;
            end
            seen_stats = 1'b1;
            e.counted  = 1'b1;
          end
        end
      end
      e.stats_valid  = seen_stats;
      e.min_rate     = least_fps;
      e.max_rate     = most_fps;
      e.avg_rate     = frst_pkg::RATE_W'(avg_acc >> frst_pkg::AVG_EXTRA_BITS);
      e.min_avg_rate = least_avg;
      e.max_avg_rate = most_avg;
      predicted.push_back(e);
    endfunction

    function void field_check(string name, logic [frst_pkg::RATE_W-1:0] want,
                              logic [frst_pkg::RATE_W-1:0] got);
      if (want !== got) begin
        mismatch_count++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_stats(stats_t got);
      stats_t want;
      if (predicted.size() == 0) begin
        mismatch_count++;
        $display("%0t: stray beat expected none actual counted=%0d", $time, got.counted);
        return;
      end
      want = predicted.pop_front();
      field_check("counted", frst_pkg::RATE_W'(want.counted),
                  frst_pkg::RATE_W'(got.counted));
      field_check("stats_valid", frst_pkg::RATE_W'(want.stats_valid),
                  frst_pkg::RATE_W'(got.stats_valid));
      field_check("min_rate", want.min_rate, got.min_rate);
      field_check("max_rate", want.max_rate, got.max_rate);
      field_check("avg_rate", want.avg_rate, got.avg_rate);
      field_check("min_avg_rate", want.min_avg_rate, got.min_avg_rate);
      field_check("max_avg_rate", want.max_avg_rate, got.max_avg_rate);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [frst_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [frst_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            idle_on;
  logic                            long_req;
  logic [frst_pkg::TIME_W-1:0]     stamp;
  int unsigned                     span;
  int unsigned                     cycle_count;
  stats_scoreboard                 sb;

  frst_in_if  in_ch();
  frst_out_if out_ch();

  frame_rate_statistics_tracker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // statistics beat monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_stats({out_ch.counted, out_ch.stats_valid, out_ch.min_rate,
                      out_ch.max_rate, out_ch.avg_rate, out_ch.min_avg_rate,
                      out_ch.max_avg_rate});
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    int unsigned hold;
    bit          long_done;
    hold      = 0;
    long_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (long_req && !long_done) begin
        long_done = 1'b1;
        hold      = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic frame_t frame_of(input logic act,
                                      input logic [frst_pkg::TIME_W-1:0] t,
                                      input logic [frst_pkg::COMP_W-1:0] c0, c1, c2,
                                                                         c3, c4, c5);
    frame_t f;
    f.active  = act;
    f.now_ms  = t;
    f.comp[0] = c0;
    f.comp[1] = c1;
    f.comp[2] = c2;
    f.comp[3] = c3;
    f.comp[4] = c4;
    f.comp[5] = c5;
    return f;
  endfunction

  function automatic frame_t rand_frame();
    frame_t      f;
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      f.active = 1'($urandom_range(0, 1));
      stamp    = $urandom;
    end else if (kind == 1) begin
      // leaving the game reopens the settle window
      f.active = 1'b0;
      stamp    = stamp + $urandom_range(0, span);
    end else if (kind == 2) begin
      f.active = 1'b1;
      stamp    = stamp - $urandom_range(0, span);
    end else begin
      f.active = 1'b1;
      stamp    = stamp + $urandom_range(0, span);
    end
    f.now_ms = stamp;
    kind = $urandom_range(0, 9);
    pick = $urandom_range(0, frst_pkg::NUM_COMP - 1);
    for (int i = 0; i < frst_pkg::NUM_COMP; i++) begin
      case (kind)
        6:       f.comp[i] = frst_pkg::COMP_W'($urandom_range(0, 1000000));
        7:       f.comp[i] = (i == pick) ? frst_pkg::COMP_W'($urandom_range(0, 1000000))
                                         : '0;
        8:       f.comp[i] = frst_pkg::COMP_W'($urandom_range(0, 20));
        9:       f.comp[i] = frst_pkg::COMP_W'($urandom_range(15, 170));
        default: f.comp[i] = frst_pkg::COMP_W'($urandom_range(0, 6000));
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    in_ch.valid     <= 1'b1;
    in_ch.active    <= f.active;
    in_ch.now_ms    <= f.now_ms;
    in_ch.input_us  <= f.comp[0];
    in_ch.client_us <= f.comp[1];
    in_ch.render_us <= f.comp[2];
    in_ch.sound_us  <= f.comp[3];
    in_ch.module_us <= f.comp[4];
    in_ch.exec_us   <= f.comp[5];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_frame(f);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [frst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frst_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic write_settings(input logic ded, input logic [15:0] settle,
                                input logic [15:0] weight);
    write_reg(frst_pkg::CFG_DEDICATED, frst_pkg::CFG_DATA_W'(ded));
    write_reg(frst_pkg::CFG_SETTLE, settle);
    write_reg(frst_pkg::CFG_KEEP, weight);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned count;
    logic        ded;
    logic [15:0] settle;
    logic [15:0] weight;
    sb = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= frst_pkg::CFG_DEDICATED;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.active    <= 1'b0;
    in_ch.now_ms    <= '0;
    in_ch.input_us  <= '0;
    in_ch.client_us <= '0;
    in_ch.render_us <= '0;
    in_ch.sound_us  <= '0;
    in_ch.module_us <= '0;
    in_ch.exec_us   <= '0;
    idle_on         <= 1'b1;
    long_req        <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings: settle window of 10000 ms
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_frame(frame_of(1, 1000, 1000, 1000, 1000, 1000, 1000, 1000));
    send_frame(frame_of(1, 5000, 1000, 1000, 1000, 1000, 1000, 1000));
    send_frame(frame_of(1, 10999, 1000, 1000, 1000, 1000, 1000, 1000));
    send_frame(frame_of(1, 11000, 0, 0, 0, 0, 0, 0));
    send_frame(frame_of(1, 11001, 99, 0, 0, 0, 0, 0));
    send_frame(frame_of(1, 11002, 0, 0, 0, 0, 0, 100));
    send_frame(frame_of(1, 11003, 0, 1001, 0, 0, 0, 0));
    send_frame(frame_of(1, 11004, 0, 0, 1002, 0, 0, 0));
    send_frame(frame_of(1, 11005, 1000000, 1000000, 1000000, 1000000, 1000000,
                        1000000));
    send_frame(frame_of(1, 11006, 0, 0, 0, 1000000, 0, 0));
    // just inside and just past half the time stamp range from the deadline
    send_frame(frame_of(1, 32'd11000 + 32'h8000_0001, 4000, 3000, 2000, 1000, 500, 250));
    send_frame(frame_of(1, 32'd11000 + 32'h8000_0000, 4000, 3000, 2000, 1000, 500, 250));
    send_frame(frame_of(0, 32'd20000, 0, 0, 0, 0, 0, 0));
    // deadline wraps past zero
    send_frame(frame_of(1, 32'hFFFF_F000, 1, 2, 3, 4, 5, 6));
    send_frame(frame_of(1, 32'h0000_0100, 1000, 1000, 1000, 1000, 1000, 1000));
    send_frame(frame_of(1, 32'h0000_1710, 8000, 8000, 700, 0, 0, 0));
    send_frame(frame_of(1, 32'h0000_1711, 2000, 9000, 4000, 500, 600, 567));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       begin ded = 1'b0; settle = 16'd0;     weight = 16'd64881; end
        1:       begin ded = 1'b0; settle = 16'd65535; weight = 16'd0;     end
        2:       begin ded = 1'b0; settle = 16'd37;    weight = 16'd65535; end
        3:       begin ded = 1'b0; settle = 16'($urandom); weight = 16'($urandom); end
        4:       begin ded = 1'b1; settle = 16'd200;   weight = 16'd1000;  end
        5:       begin ded = 1'b0; settle = 16'd200;   weight = 16'd32768; end
        6:       begin
          ded    = 1'b0;
          settle = 16'($urandom_range(0, 2000));
          weight = 16'($urandom);
        end
        7:       begin ded = 1'b0; settle = 16'd1;     weight = 16'd65534; end
        8:       begin ded = 1'b0; settle = 16'd500;   weight = 16'd1;     end
        default: begin ded = 1'b0; settle = 16'd10000; weight = 16'd64881; end
      endcase
      write_settings(ded, settle, weight);
      span  = settle / 4 + 8;
      stamp = (p == 8) ? 32'hFFFF_0000 : $urandom;
      if (p == PHASES - 1) idle_on <= 1'b0;
      if (p == 3) long_req <= 1'b1;
      count = (p == 4) ? 40 : 136;
      for (int n = 0; n < count; n++) begin
        if (p == 5 && n == 60) drain_results();
        send_frame(rand_frame());
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/frst_pkg.sv
rtl/core/frst_in_if.sv
rtl/core/frst_out_if.sv
rtl/core/frst_div.sv
rtl/core/frst_mac.sv
rtl/core/frame_rate_statistics_tracker_core.sv
sim/frame_rate_statistics_tracker_core_test.sv
